>>> hdl/mcfp_pkg.sv
// shared types and constants for the motor command frame packer
package mcfp_pkg;

  localparam int POS_CODE_BITS = 16;
  localparam int AUX_CODE_BITS = 12;
  localparam int FRAC_BITS_DEF = 16;
  localparam int GAIN_BITS     = 12;
  localparam int IDENT_BITS    = 11;
  localparam int DATA_W        = 64;
  localparam int ADDR_W        = 6;
  localparam int VAL_W         = 32;

  // register index, taken from paddr[5:3]
  typedef enum logic [2:0] {
    REG_POS_WIN   = 3'd0,
    REG_VEL_WIN   = 3'd1,
    REG_EFF_WIN   = 3'd2,
    REG_POS_SCALE = 3'd3,
    REG_VEL_SCALE = 3'd4,
    REG_EFF_SCALE = 3'd5,
    REG_GAINS     = 3'd6,
    REG_JOINT     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [VAL_W-1:0] mn;
    logic [VAL_W-1:0]        scale;
  } axis_cfg_t;

  typedef struct packed {
    axis_cfg_t             pos;
    axis_cfg_t             vel;
    axis_cfg_t             eff;
    logic [GAIN_BITS-1:0]  kp;
    logic [GAIN_BITS-1:0]  kd;
    logic                  invert;
    logic [IDENT_BITS-1:0] ident;
  } cfg_t;

  // per-stage advance strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

>>> hdl/mcfp_regs.sv
// apb configuration registers of the frame packer
module mcfp_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mcfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [mcfp_pkg::DATA_W-1:0]   pwdata,
  output logic [mcfp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mcfp_pkg::cfg_t                cfg
);
  import mcfp_pkg::*;

  logic [DATA_W-1:0]      pos_win_r, vel_win_r, eff_win_r;
  logic [DATA_W-1:0]      pos_scl_r, vel_scl_r, eff_scl_r;
  logic [2*GAIN_BITS-1:0] gains_r;
  logic [IDENT_BITS:0]    joint_r;
  reg_idx_t               idx;
  logic                   wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_win_r <= '0;
      vel_win_r <= '0;
      eff_win_r <= '0;
      pos_scl_r <= '0;
      vel_scl_r <= '0;
      eff_scl_r <= '0;
      gains_r   <= '0;
      joint_r   <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_POS_WIN:   pos_win_r <= pwdata;
        REG_VEL_WIN:   vel_win_r <= pwdata;
        REG_EFF_WIN:   eff_win_r <= pwdata;
        REG_POS_SCALE: pos_scl_r <= pwdata;
        REG_VEL_SCALE: vel_scl_r <= pwdata;
        REG_EFF_SCALE: eff_scl_r <= pwdata;
        REG_GAINS:     gains_r   <= pwdata[2*GAIN_BITS-1:0];
        REG_JOINT:     joint_r   <= pwdata[IDENT_BITS:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POS_WIN:   prdata = pos_win_r;
      REG_VEL_WIN:   prdata = vel_win_r;
      REG_EFF_WIN:   prdata = eff_win_r;
      REG_POS_SCALE: prdata = pos_scl_r;
      REG_VEL_SCALE: prdata = vel_scl_r;
      REG_EFF_SCALE: prdata = eff_scl_r;
      REG_GAINS:     prdata = {{(DATA_W-2*GAIN_BITS){1'b0}}, gains_r};
      REG_JOINT:     prdata = {{(DATA_W-IDENT_BITS-1){1'b0}}, joint_r};
      default:       prdata = '0;
    endcase
  end

  // window: low in upper word, high in lower; scaling: minimum upper, scale lower
  always_comb begin
    cfg.pos.lo    = $signed(pos_win_r[63:32]);
    cfg.pos.hi    = $signed(pos_win_r[31:0]);
    cfg.pos.mn    = $signed(pos_scl_r[63:32]);
    cfg.pos.scale = pos_scl_r[31:0];
    cfg.vel.lo    = $signed(vel_win_r[63:32]);
    cfg.vel.hi    = $signed(vel_win_r[31:0]);
    cfg.vel.mn    = $signed(vel_scl_r[63:32]);
    cfg.vel.scale = vel_scl_r[31:0];
    cfg.eff.lo    = $signed(eff_win_r[63:32]);
    cfg.eff.hi    = $signed(eff_win_r[31:0]);
    cfg.eff.mn    = $signed(eff_scl_r[63:32]);
    cfg.eff.scale = eff_scl_r[31:0];
    cfg.kp        = gains_r[2*GAIN_BITS-1:GAIN_BITS];
    cfg.kd        = gains_r[GAIN_BITS-1:0];
    cfg.invert    = joint_r[IDENT_BITS];
    cfg.ident     = joint_r[IDENT_BITS-1:0];
  end

endmodule

>>> hdl/mcfp_quant.sv
// four-stage invert, clamp, offset, scale and saturate datapath for one axis
module mcfp_quant #(
  parameter int CODE_BITS = mcfp_pkg::AUX_CODE_BITS,
  parameter int FRAC_BITS = mcfp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  mcfp_pkg::stage_en_t                en,
  input  logic                               invert,
  input  mcfp_pkg::axis_cfg_t                acfg,
  input  logic signed [mcfp_pkg::VAL_W-1:0]  cmd,
  output logic [CODE_BITS-1:0]               code
);
  import mcfp_pkg::*;

  localparam int SH = 2 * FRAC_BITS;

  logic signed [VAL_W:0]   cmd_ext, inv_v, lo_ext, hi_ext, raise_v, clamp_v;
  logic signed [VAL_W:0]   diff_v;
  logic signed [VAL_W-1:0] clamp_r;
  logic [VAL_W-1:0]        diff_r;
  logic [2*VAL_W-1:0]      prod_r;
  logic [2*VAL_W-1:0]      shifted;
  logic [CODE_BITS-1:0]    code_r;
  logic                    below_min;

  // stage 1: negate at 33 bits when invert is set, raise to low bound then lower to high bound
  always_comb begin
    cmd_ext = {cmd[VAL_W-1], cmd};
    lo_ext  = {acfg.lo[VAL_W-1], acfg.lo};
    hi_ext  = {acfg.hi[VAL_W-1], acfg.hi};
    inv_v   = invert ? -cmd_ext : cmd_ext;
    raise_v = (inv_v < lo_ext) ? lo_ext : inv_v;
    clamp_v = (raise_v > hi_ext) ? hi_ext : raise_v;
  end

  // stage 2: offset from range minimum, zero at or below it
  always_comb begin
    diff_v    = {clamp_r[VAL_W-1], clamp_r} - {acfg.mn[VAL_W-1], acfg.mn};
    below_min = diff_v[VAL_W] || (diff_v == '0);
  end

  // stage 4: drop fraction bits and saturate
  assign shifted = prod_r >> SH;

  always_ff @(posedge clk) begin
    if (en.s1) clamp_r <= clamp_v[VAL_W-1:0];
    if (en.s2) diff_r  <= below_min ? '0 : diff_v[VAL_W-1:0];
    if (en.s3) prod_r  <= (2*VAL_W)'(diff_r) * (2*VAL_W)'(acfg.scale);
    if (en.s4) code_r  <= (|shifted[2*VAL_W-1:CODE_BITS]) ? '1
                                                           : shifted[CODE_BITS-1:0];
  end

  assign code = code_r;

endmodule

>>> hdl/motor_command_frame_packer_unit.sv
// top level of the motor command frame packer
//
//  channel   direction  handshake            payload
//  in        sink       in_valid/in_stall    in_pos_cmd, in_vel_cmd, in_eff_cmd
//  out       source     out_valid/out_stall  out_frame_ident, out_frame_payload
//  cfg       apb slave  psel/penable/pready  paddr, pwdata, prdata
//
// one command per clock while in_stall is low; each command passes through every stage in order
// stages: clamp, offset, 32x32 multiply, saturate; the multiplier sets the stage depth
// synchronous active-low reset empties the pipeline and clears the registers
// each stage holds while it is full and the one after it is holding; bubbles are squeezed
// out, so in_stall only rises when all four stages are full and out_stall is high
module motor_command_frame_packer_unit #(
  parameter int FRAC_BITS = mcfp_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // command input
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [mcfp_pkg::VAL_W-1:0]      in_pos_cmd,
  input  logic signed [mcfp_pkg::VAL_W-1:0]      in_vel_cmd,
  input  logic signed [mcfp_pkg::VAL_W-1:0]      in_eff_cmd,
  // frame output
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mcfp_pkg::IDENT_BITS-1:0]        out_frame_ident,
  output logic [mcfp_pkg::DATA_W-1:0]            out_frame_payload,
  // configuration
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mcfp_pkg::ADDR_W-1:0]            paddr,
  input  logic [mcfp_pkg::DATA_W-1:0]            pwdata,
  output logic [mcfp_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready
);
  import mcfp_pkg::*;

  cfg_t                     cfg;
  stage_en_t                en;
  logic [3:0]               vld_r, vld_nxt;
  logic [POS_CODE_BITS-1:0] pos_code;
  logic [AUX_CODE_BITS-1:0] vel_code, eff_code;

  mcfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a stage may load when it is empty or its contents move on this cycle
  always_comb begin
    en.s4 = !vld_r[3] || !out_stall;
    en.s3 = !vld_r[2] || en.s4;
    en.s2 = !vld_r[1] || en.s3;
    en.s1 = !vld_r[0] || en.s2;
  end

  // valid bits travel alongside the data
  always_comb begin
    vld_nxt[0] = en.s1 ? in_valid : vld_r[0];
    vld_nxt[1] = en.s2 ? vld_r[0] : vld_r[1];
    vld_nxt[2] = en.s3 ? vld_r[1] : vld_r[2];
    vld_nxt[3] = en.s4 ? vld_r[2] : vld_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !en.s1;

  // three identical axis datapaths, only the code width differs
  mcfp_quant #(.CODE_BITS(POS_CODE_BITS), .FRAC_BITS(FRAC_BITS)) u_pos (
    .clk    (clk),
    .en     (en),
    .invert (cfg.invert),
    .acfg   (cfg.pos),
    .cmd    (in_pos_cmd),
    .code   (pos_code)
  );

  mcfp_quant #(.CODE_BITS(AUX_CODE_BITS), .FRAC_BITS(FRAC_BITS)) u_vel (
    .clk    (clk),
    .en     (en),
    .invert (cfg.invert),
    .acfg   (cfg.vel),
    .cmd    (in_vel_cmd),
    .code   (vel_code)
  );

  mcfp_quant #(.CODE_BITS(AUX_CODE_BITS), .FRAC_BITS(FRAC_BITS)) u_eff (
    .clk    (clk),
    .en     (en),
    .invert (cfg.invert),
    .acfg   (cfg.eff),
    .cmd    (in_eff_cmd),
    .code   (eff_code)
  );

  // frame layout: position, velocity, stiffness, damping, torque; byte 0 on top
  // gains and identifier must be kept static while frames are in flight; the block does not enforce it
  assign out_valid         = vld_r[3];
  assign out_frame_ident   = cfg.ident;
  assign out_frame_payload = {pos_code, vel_code, cfg.kp, cfg.kd, eff_code};

endmodule

>>> hdl/mcfp_checker.sv
// port-level checker for the frame packer, bound to the top level
module mcfp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [mcfp_pkg::DATA_W-1:0]   out_frame_payload
);

  // a stalled frame stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled frame dropped");

  // a stalled frame does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_frame_payload))
    else $error("stalled frame changed");

  // with out_stall low while it passes the stages, a transfer reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("frame missing after four cycles");

  // reset empties the pipeline and opens the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind motor_command_frame_packer_unit mcfp_checker u_mcfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_payload (out_frame_payload)
);
